>>> rtl/distance_vector_route_table_assert.svh
// Assertion macros shared by the route table RTL.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define DVRT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define DVRT_ASSERT_THEN(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define DVRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dvrt_pkg.sv
// Types, codes and helpers shared by the route table RTL.
`timescale 1ns / 1ps

package dvrt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ADVERT_MAX_DEF  = 25;
    localparam logic [15:0] COST_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_HELLO  = 2'd0,
        FUNC_ROUTE  = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_ADVERT = 2'd3
    } dvrt_func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] dest_ip;
        logic [15:0] metric;
        logic [15:0] link_cost;
    } dvrt_in_t;

    typedef struct packed {
        logic [31:0] route_ip;
        logic [15:0] route_cost;
        logic        found;
        logic        table_full;
        logic        last;
    } dvrt_out_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] cost;
    } dvrt_entry_t;

    // Saturating 16-bit cost add.
    function automatic logic [15:0] cost_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[16] ? COST_MAX : sum[15:0];
    endfunction

endpackage

>>> rtl/distance_vector_route_table.sv
// Top level of the distance-vector route table.
`timescale 1ns / 1ps
`include "distance_vector_route_table_assert.svh"

// Distance-vector route table. Entries (address, cost) live in a ring of
// TABLE_DEPTH cells kept in insertion order; cell 0 is the head that the
// controller inspects. Every command item rotates the ring one full turn,
// one cell per cycle, so that after the turn the table is back in order.
// On the way round the controller matches the head against dest_ip; for
// hello and route items it keeps the lower cost on a hit and appends a
// new entry at the fill position if no hit came first and room is left.
// An item is accepted, the ring advances once per cell, and a last step
// posts the result. An advertise item emits one result per live entry, up
// to ADVERT_MAX, and its rotation stalls whenever the result register is
// still held by the receiver. No reset sweep is needed: a fill count marks
// which cells are live. A new command is taken as soon as the previous one
// has posted its result, even while that result still waits on rsp_stall.
module distance_vector_route_table #(
    parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEF,
    parameter int ADVERT_MAX  = dvrt_pkg::ADVERT_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  dvrt_pkg::dvrt_in_t  cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dvrt_pkg::dvrt_out_t rsp
);
    import dvrt_pkg::*;

    // Counter width: holds 0..TABLE_DEPTH.
    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg, state_next;
    logic [CntW-1:0]  step_reg, step_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             found_reg, found_next;
    logic             rsp_valid_reg, rsp_valid_next;

    dvrt_in_t         cmd_reg, cmd_next;
    logic [15:0]      offer_reg, offer_next;
    logic [15:0]      hit_cost_reg, hit_cost_next;
    logic [CntW-1:0]  adv_n_reg, adv_n_next;
    dvrt_out_t        rsp_reg, rsp_next;

    // Ring of cells.
    dvrt_entry_t      chain_q [TABLE_DEPTH];
    dvrt_entry_t      wrap;
    logic             shift_en;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            dvrt_entry_t cell_din;
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign cell_din = wrap;
            end
            else
            begin : g_body
                assign cell_din = chain_q[gi+1];
            end
            dvrt_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .din      (cell_din),
                .dout     (chain_q[gi])
            );
        end
    endgenerate

    dvrt_entry_t head;
    logic        live, at_end, is_offer, is_adv, hit, ins, out_free, emit_end;
    logic [15:0] min_cost;

    assign head     = chain_q[0];
    assign live     = step_reg < count_reg;
    assign at_end   = step_reg == CntW'(TABLE_DEPTH);
    assign is_offer = cmd_reg.func == FUNC_HELLO || cmd_reg.func == FUNC_ROUTE;
    assign is_adv   = cmd_reg.func == FUNC_ADVERT;
    assign hit      = live && !found_reg && !is_adv && head.addr == cmd_reg.dest_ip;
    // Append at the fill position when nothing matched ahead of it.
    assign ins      = is_offer && !found_reg && step_reg == count_reg
                      && count_reg != CntW'(TABLE_DEPTH);
    assign min_cost = (head.cost > offer_reg) ? offer_reg : head.cost;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    // Advertise posts nothing at the end unless the table was empty.
    assign emit_end = !is_adv || adv_n_reg == '0;

    assign cmd_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        cmd_next       = cmd_reg;
        offer_next     = offer_reg;
        hit_cost_next  = hit_cost_reg;
        adv_n_next     = adv_n_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        shift_en       = 1'b0;
        wrap           = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                    found_next = 1'b0;
                    cmd_next   = cmd;
                    offer_next = (cmd.func == FUNC_ROUTE)
                                 ? cost_add(cmd.metric, cmd.link_cost) : cmd.link_cost;
                    if (32'(count_reg) > 32'(ADVERT_MAX))
                    begin
                        adv_n_next = CntW'(ADVERT_MAX);
                    end
                    else
                    begin
                        adv_n_next = count_reg;
                    end
                end
            end
            ST_SCAN:
            begin
                if (at_end)
                begin
                    if (!emit_end || out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                    if (emit_end && out_free)
                    begin
                        rsp_valid_next      = 1'b1;
                        rsp_next.route_ip   = is_adv ? 32'd0 : cmd_reg.dest_ip;
                        rsp_next.route_cost = found_reg ? hit_cost_reg : 16'd0;
                        rsp_next.found      = found_reg;
                        rsp_next.table_full = is_offer && !found_reg;
                        rsp_next.last       = 1'b1;
                    end
                end
                else if (is_adv && step_reg < adv_n_reg)
                begin
                    // Emit the head; hold the ring while the output is busy.
                    if (out_free)
                    begin
                        shift_en            = 1'b1;
                        step_next           = step_reg + CntW'(1);
                        rsp_valid_next      = 1'b1;
                        rsp_next.route_ip   = head.addr;
                        rsp_next.route_cost = head.cost;
                        rsp_next.found      = 1'b1;
                        rsp_next.table_full = 1'b0;
                        rsp_next.last       = (step_reg + CntW'(1)) == adv_n_reg;
                    end
                end
                else
                begin
                    shift_en  = 1'b1;
                    step_next = step_reg + CntW'(1);
                    if (hit)
                    begin
                        found_next = 1'b1;
                        if (is_offer)
                        begin
                            wrap.cost     = min_cost;
                            hit_cost_next = min_cost;
                        end
                        else
                        begin
                            hit_cost_next = head.cost;
                        end
                    end
                    else if (ins)
                    begin
                        found_next    = 1'b1;
                        wrap.addr     = cmd_reg.dest_ip;
                        wrap.cost     = offer_reg;
                        hit_cost_next = offer_reg;
                        count_next    = count_reg + CntW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        offer_reg    <= offer_next;
        hit_cost_reg <= hit_cost_next;
        adv_n_reg    <= adv_n_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DVRT_ASSERT_ALWAYS(a_count_bound, count_reg <= CntW'(TABLE_DEPTH), "fill count above depth")
    `DVRT_ASSERT_NEXT(a_idle_count, state_reg == ST_IDLE, $stable(count_reg), "table changed while idle")
    `DVRT_ASSERT_THEN(a_full_flag, rsp_valid_reg && rsp_reg.table_full, count_reg == CntW'(TABLE_DEPTH), "drop flagged with room left")
    `DVRT_ASSERT_NEXT(a_start_scan, cmd_valid && !cmd_stall, state_reg == ST_SCAN && step_reg == '0, "scan did not start")

endmodule

>>> rtl/dvrt_cell.sv
// One table cell: holds an address and cost, passes them on when the ring advances.
`timescale 1ns / 1ps

module dvrt_cell (
    input  logic                clk,
    input  logic                shift_en,
    input  dvrt_pkg::dvrt_entry_t din,
    output dvrt_pkg::dvrt_entry_t dout
);
    import dvrt_pkg::*;

    dvrt_entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule

>>> bench/dvrt_checker.sv
// Route table checker: predicts results from accepted command items and compares them.
`timescale 1ns / 1ps

module dvrt_checker #(
    parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEF,
    parameter int ADVERT_MAX  = dvrt_pkg::ADVERT_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  dvrt_pkg::dvrt_in_t  cmd,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  dvrt_pkg::dvrt_out_t rsp,
    output int                  mismatches,
    output int                  pending,
    output int                  checked,
    output int                  full_drops
);

    // Shadow copy of the route table.
    logic [31:0] shadow_addr [TABLE_DEPTH];
    logic [15:0] shadow_cost [TABLE_DEPTH];
    int          shadow_count;

    dvrt_pkg::dvrt_out_t route_expect_q [$];

    int err_cnt;
    int seen_cnt;
    int drop_cnt;

    function automatic dvrt_pkg::dvrt_out_t make_route_rsp(
        input logic [31:0] ip,
        input logic [15:0] cost,
        input logic        hit,
        input logic        full,
        input logic        fin
    );
        dvrt_pkg::dvrt_out_t r;
        r.route_ip   = ip;
        r.route_cost = cost;
        r.found      = hit;
        r.table_full = full;
        r.last       = fin;
        return r;
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void add_expect(input dvrt_pkg::dvrt_out_t r);
        route_expect_q.insert(route_expect_q.size(), r);
    endfunction

    function automatic int find_route(input logic [31:0] ip);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_addr[i] == ip)
                return i;
        end
        return -1;
    endfunction

    task automatic predict_route_rsp(input dvrt_pkg::dvrt_in_t item);
        int          idx;
        int          n;
        logic [16:0] sum;
        logic [15:0] offer_cost;
        case (item.func)
            dvrt_pkg::FUNC_HELLO, dvrt_pkg::FUNC_ROUTE:
            begin
                if (item.func == dvrt_pkg::FUNC_ROUTE)
                begin
                    sum        = {1'b0, item.metric} + {1'b0, item.link_cost};
                    offer_cost = sum[16] ? dvrt_pkg::COST_MAX : sum[15:0];
                end
                else
                    offer_cost = item.link_cost;
                idx = find_route(item.dest_ip);
                if (idx >= 0)
                begin
                    // Keep the lower of stored and offered cost.
                    if (shadow_cost[idx] > offer_cost)
                        shadow_cost[idx] = offer_cost;
                    add_expect(
                        make_route_rsp(item.dest_ip, shadow_cost[idx], 1'b1, 1'b0, 1'b1));
                end
                else if (shadow_count < TABLE_DEPTH)
                begin
                    shadow_addr[shadow_count] = item.dest_ip;
                    shadow_cost[shadow_count] = offer_cost;
                    shadow_count++;
                    add_expect(
                        make_route_rsp(item.dest_ip, offer_cost, 1'b1, 1'b0, 1'b1));
                end
                else
                begin
                    // Drop the new address: no room left.
                    drop_cnt++;
                    add_expect(
                        make_route_rsp(item.dest_ip, 16'd0, 1'b0, 1'b1, 1'b1));
                end
            end
            dvrt_pkg::FUNC_QUERY:
            begin
                idx = find_route(item.dest_ip);
                if (idx >= 0)
                    add_expect(
                        make_route_rsp(item.dest_ip, shadow_cost[idx], 1'b1, 1'b0, 1'b1));
                else
                    add_expect(
                        make_route_rsp(item.dest_ip, 16'd0, 1'b0, 1'b0, 1'b1));
            end
            default:
            begin
                n = (shadow_count < ADVERT_MAX) ? shadow_count : ADVERT_MAX;
                if (n == 0)
                    add_expect(make_route_rsp(32'd0, 16'd0, 1'b0, 1'b0, 1'b1));
                for (int i = 0; i < n; i++)
                begin
                    add_expect(make_route_rsp(shadow_addr[i], shadow_cost[i],
                                              1'b1, 1'b0, (i == n - 1)));
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dvrt_pkg::dvrt_out_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            route_expect_q.delete();
            err_cnt  = 0;
            seen_cnt = 0;
            drop_cnt = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                seen_cnt++;
                if (route_expect_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected result ip=%h cost=%h found=%b full=%b last=%b",
                                 $realtime, rsp.route_ip, rsp.route_cost, rsp.found,
                                 rsp.table_full, rsp.last);
                end
                else
                begin
                    want = route_expect_q.pop_front();
                    if (rsp.route_ip !== want.route_ip || rsp.route_cost !== want.route_cost ||
                        rsp.found !== want.found || rsp.table_full !== want.table_full ||
                        rsp.last !== want.last)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $display("%0t: mismatch on result %0d", $realtime, seen_cnt);
                            $display("    expected ip=%h cost=%h found=%b full=%b last=%b",
                                     want.route_ip, want.route_cost, want.found,
                                     want.table_full, want.last);
                            $display("    actual   ip=%h cost=%h found=%b full=%b last=%b",
                                     rsp.route_ip, rsp.route_cost, rsp.found,
                                     rsp.table_full, rsp.last);
                        end
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                predict_route_rsp(cmd);
        end
        mismatches <= err_cnt;
        pending    <= route_expect_q.size();
        checked    <= seen_cnt;
        full_drops <= drop_cnt;
    end

endmodule

>>> bench/tb.sv
// Testbench top for the route table: drives command items, stalls results, gives the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH  = dvrt_pkg::TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 395;
    localparam int QUIET_ITEMS  = 60;
    localparam int POOL_SIZE    = 48;
    // One full ring turn plus margin, taken a few times over.
    localparam int DRAIN_CYCLES = 4 * (TABLE_DEPTH + 2) + 20;
    localparam int LIMIT_NS     = 1_500_000;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    dvrt_pkg::dvrt_in_t  cmd;
    logic                rsp_valid;
    logic                rsp_stall;
    dvrt_pkg::dvrt_out_t rsp;

    int mismatches;
    int pending;
    int checked;
    int full_drops;

    // Enable random idling on both channels; cleared for quiet stretches.
    bit          idle_on;
    int          func_cnt [4];
    logic [31:0] addr_pool [POOL_SIZE];

    distance_vector_route_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    dvrt_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .full_drops (full_drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run in case the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    // Hold off results in random bursts; one assignment per falling edge.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 99) < 15)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    function automatic dvrt_pkg::dvrt_in_t make_cmd(
        input dvrt_pkg::dvrt_func_t op,
        input logic [31:0]          ip,
        input logic [15:0]          metric,
        input logic [15:0]          link
    );
        dvrt_pkg::dvrt_in_t c;
        c.func      = op;
        c.dest_ip   = ip;
        c.metric    = metric;
        c.link_cost = link;
        return c;
    endfunction

    // Bias costs toward small values so that lower offers replace stored ones,
    // and toward the top so that sums saturate.
    function automatic logic [15:0] pick_cost();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 40));
            5:       return 16'hFFFF - 16'($urandom_range(0, 40));
            6:       return 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Draw addresses mostly from the pool so that hits, updates and
    // table-full drops all occur.
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 99) < 85)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic dvrt_pkg::dvrt_in_t random_cmd();
        int                   roll;
        dvrt_pkg::dvrt_func_t op;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            op = dvrt_pkg::FUNC_HELLO;
        else if (roll < 60)
            op = dvrt_pkg::FUNC_ROUTE;
        else if (roll < 85)
            op = dvrt_pkg::FUNC_QUERY;
        else
            op = dvrt_pkg::FUNC_ADVERT;
        return make_cmd(op, pick_addr(), pick_cost(), pick_cost());
    endfunction

    // Present one item at the falling edge and hold it until accepted.
    task automatic send_cmd(input dvrt_pkg::dvrt_in_t item);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        func_cnt[item.func]++;
    endtask

    // Drop valid for a random burst now and then.
    task automatic cmd_gap();
        if (idle_on && $urandom_range(0, 99) < 25)
        begin
            repeat ($urandom_range(1, 10))
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        idle_on   = 1'b1;
        for (int i = 0; i < 4; i++)
            func_cnt[i] = 0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, extreme addresses and costs, saturation,
        // keep-lower updates, hits and misses, short advertisements.
        send_cmd(make_cmd(dvrt_pkg::FUNC_ADVERT, 32'h0, 16'h0, 16'h0));
        send_cmd(make_cmd(dvrt_pkg::FUNC_QUERY, addr_pool[2], 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(dvrt_pkg::FUNC_HELLO, 32'h0000_0000, 16'h0000, 16'h0000));
        send_cmd(make_cmd(dvrt_pkg::FUNC_HELLO, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ADVERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ROUTE, addr_pool[2], 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ROUTE, addr_pool[2], 16'h8000, 16'h7FFF));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ROUTE, addr_pool[2], 16'h0001, 16'h0002));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ROUTE, addr_pool[2], 16'h0064, 16'h0064));
        send_cmd(make_cmd(dvrt_pkg::FUNC_HELLO, 32'hFFFF_FFFF, 16'h1234, 16'h0000));
        send_cmd(make_cmd(dvrt_pkg::FUNC_HELLO, 32'h0000_0000, 16'h0000, 16'hFFFF));
        send_cmd(make_cmd(dvrt_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 16'h0000, 16'h0000));
        send_cmd(make_cmd(dvrt_pkg::FUNC_QUERY, addr_pool[3], 16'h0000, 16'h0000));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ADVERT, $urandom, pick_cost(), pick_cost()));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ROUTE, addr_pool[3], 16'h0000, 16'h0000));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ROUTE, addr_pool[3], 16'hFFFF, 16'h0001));
        send_cmd(make_cmd(dvrt_pkg::FUNC_QUERY, addr_pool[2], 16'hFFFF, 16'hFFFF));
        send_cmd(make_cmd(dvrt_pkg::FUNC_ADVERT, 32'h0, 16'h0, 16'h0));

        // Random part: fills the table past capacity and advertises it as it
        // grows; one stretch in the middle and the tail run without idling.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_on = !(i >= 150 && i < 200) && (i < RANDOM_ITEMS - QUIET_ITEMS);
            cmd_gap();
            send_cmd(random_cmd());
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        idle_on = 1'b0;

        // Drain outstanding results, then allow time for stray ones.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d items: %0d hello, %0d route, %0d query, %0d advertise.",
                 func_cnt[0] + func_cnt[1] + func_cnt[2] + func_cnt[3],
                 func_cnt[0], func_cnt[1], func_cnt[2], func_cnt[3]);
        $display("Checked %0d results, %0d offers dropped on a full table, %0d mismatches.",
                 checked, full_drops, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
